### design/sdas_pkg.sv
// Package with the types, constants and digit functions of the signed decimal unit.
`timescale 1ns / 1ps
package sdas_pkg;

  localparam int unsigned MaxDigits     = 16;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned WordW         = MaxDigits * DigitW;
  localparam int unsigned DigitsDefault = 16;
  localparam int unsigned KindW         = 2;

  localparam logic [DigitW-1:0] DigitMax = 4'd9;

  // Operation codes. Code 3 is unused and yields an all-zero result.
  typedef enum logic [KindW-1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_CMP = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             a_negative;
    logic [WordW-1:0] a_digits;
    logic             b_negative;
    logic [WordW-1:0] b_digits;
  } in_t;

  typedef struct packed {
    logic             result_negative;
    logic [WordW-1:0] result_digits;
    logic             overflow;
    logic             greater_or_equal;
  } out_t;

  // What travels from one digit cell to the next.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             a_neg;
    logic             b_neg;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] sum;      // |a| + |b|
    logic [WordW-1:0] diff_ab;  // |a| - |b|
    logic [WordW-1:0] diff_ba;  // |b| - |a|
    logic             carry;
    logic             borrow_ab;
    logic             borrow_ba;
    logic             a_zero;
    logic             b_zero;
  } stage_t;

  typedef struct packed {
    logic              c;
    logic [DigitW-1:0] d;
  } digit_res_t;

  // A nibble above nine reads as nine.
  function automatic logic [DigitW-1:0] clamp_digit(input logic [DigitW-1:0] x);
    return (x > DigitMax) ? DigitMax : x;
  endfunction

  function automatic digit_res_t add_digit(input logic [DigitW-1:0] x,
                                           input logic [DigitW-1:0] y,
                                           input logic              cin);
    logic [DigitW:0] s;
    digit_res_t      r;
    s = {1'b0, x} + {1'b0, y} + {{DigitW{1'b0}}, cin};
    if (s >= 5'd10) begin
      r.c = 1'b1;
      r.d = DigitW'(s - 5'd10);
    end else begin
      r.c = 1'b0;
      r.d = DigitW'(s);
    end
    return r;
  endfunction

  function automatic digit_res_t sub_digit(input logic [DigitW-1:0] x,
                                           input logic [DigitW-1:0] y,
                                           input logic              bin);
    logic [DigitW:0] t;
    digit_res_t      r;
    t = ({1'b0, x} + 5'd10) - ({1'b0, y} + {{DigitW{1'b0}}, bin});
    if (t >= 5'd10) begin
      r.c = 1'b0;
      r.d = DigitW'(t - 5'd10);
    end else begin
      r.c = 1'b1;
      r.d = DigitW'(t);
    end
    return r;
  endfunction

endpackage

### design/sdas_cell.sv
// One digit cell: adds and subtracts one decimal digit and registers the transaction.
`timescale 1ns / 1ps
module sdas_cell import sdas_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  stage_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output stage_t data_o
);

  logic              valid_q;
  stage_t            data_q;
  stage_t            data_d;
  logic [DigitW-1:0] da;
  logic [DigitW-1:0] db;
  digit_res_t        s_add;
  digit_res_t        s_ab;
  digit_res_t        s_ba;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    da    = clamp_digit(data_i.a[Idx*DigitW +: DigitW]);
    db    = clamp_digit(data_i.b[Idx*DigitW +: DigitW]);
    s_add = add_digit(da, db, data_i.carry);
    s_ab  = sub_digit(da, db, data_i.borrow_ab);
    s_ba  = sub_digit(db, da, data_i.borrow_ba);

    data_d = data_i;
    data_d.sum[Idx*DigitW +: DigitW]     = s_add.d;
    data_d.diff_ab[Idx*DigitW +: DigitW] = s_ab.d;
    data_d.diff_ba[Idx*DigitW +: DigitW] = s_ba.d;
    data_d.carry     = s_add.c;
    data_d.borrow_ab = s_ab.c;
    data_d.borrow_ba = s_ba.c;
    data_d.a_zero    = data_i.a_zero && (da == '0);
    data_d.b_zero    = data_i.b_zero && (db == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/sdas_out.sv
// Output stage: picks sum or difference and fixes the sign, or answers the compare, and registers the result.
`timescale 1ns / 1ps
module sdas_out import sdas_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  stage_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output out_t   data_o
);

  logic valid_q;
  out_t data_q;
  out_t data_d;
  logic b_eff;
  logic a_sign;
  logic b_sign;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = '0;
    b_eff  = (data_i.kind == KIND_SUB) ? !data_i.b_neg : data_i.b_neg;
    a_sign = data_i.a_neg && !data_i.a_zero;
    b_sign = data_i.b_neg && !data_i.b_zero;
    case (data_i.kind)
      KIND_ADD, KIND_SUB: begin
        if (data_i.a_neg == b_eff) begin
          data_d.result_digits   = data_i.sum;
          data_d.overflow        = data_i.carry;
          data_d.result_negative = data_i.a_neg;
        end else if (!data_i.borrow_ab) begin
          data_d.result_digits   = data_i.diff_ab;
          data_d.result_negative = data_i.a_neg;
        end else begin
          data_d.result_digits   = data_i.diff_ba;
          data_d.result_negative = b_eff;
        end
        if (data_d.result_digits == '0) begin
          data_d.result_negative = 1'b0;
        end
      end
      KIND_CMP: begin
        if (a_sign != b_sign) begin
          data_d.greater_or_equal = !a_sign;
        end else if (!a_sign) begin
          data_d.greater_or_equal = !data_i.borrow_ab;
        end else begin
          data_d.greater_or_equal = !data_i.borrow_ba;
        end
      end
      default: begin
        data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/signed_decimal_add_sub_compare.sv
// Top level of the signed packed-BCD add, subtract and compare unit.
`timescale 1ns / 1ps
// This unit adds, subtracts or compares two sign-magnitude packed BCD numbers of
// DIGITS digits and accepts one transaction per clock cycle unless the row stalls.
// Each transaction passes through a row of DIGITS identical digit cells, one cell per
// decimal digit from the least significant upward, followed by an output register.
// The first cell registers a transaction at the edge that accepts it, and its result
// passes through the register of every later cell and then the output register before
// it is offered on the output. Every cell works on its own digit and hands its decimal
// carry and its two borrows to the next cell, which is what sets the latency. Each
// cell computes the digit of |a| + |b|, |a| - |b| and |b| - |a| at once; the final
// borrow of |a| - |b| then tells which magnitude is larger, so the output stage picks
// the right difference, and it also answers the compare. A zero magnitude always
// comes out with a plus sign, a carry out of the top digit wraps and raises
// overflow, and operand nibbles above nine read as nine. Every stage has its own
// valid bit and stalls only when the stage after it is full, so a waiting result
// does not stop new transactions from entering while there is room in the row.
module signed_decimal_add_sub_compare import sdas_pkg::*; #(
  parameter int unsigned DIGITS = DigitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Stage 0 is the entry into the first cell; stage DIGITS feeds the output register.
  logic   stage_valid [DIGITS+1];
  logic   stage_ready [DIGITS+1];
  stage_t stage_data  [DIGITS+1];

  // Results start at zero so that nibbles from index DIGITS upward stay zero.
  always_comb begin
    stage_data[0]           = '0;
    stage_data[0].kind      = in_data_i.kind;
    stage_data[0].a_neg     = in_data_i.a_negative;
    stage_data[0].b_neg     = in_data_i.b_negative;
    stage_data[0].a         = in_data_i.a_digits;
    stage_data[0].b         = in_data_i.b_digits;
    stage_data[0].a_zero    = 1'b1;
    stage_data[0].b_zero    = 1'b1;
  end

  assign stage_valid[0] = in_valid_i;
  assign in_ready_o     = stage_ready[0];

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    sdas_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(stage_valid[k]),
      .ready_o(stage_ready[k]),
      .data_i (stage_data[k]),
      .valid_o(stage_valid[k+1]),
      .ready_i(stage_ready[k+1]),
      .data_o (stage_data[k+1])
    );
  end

  sdas_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(stage_valid[DIGITS]),
    .ready_o(stage_ready[DIGITS]),
    .data_i (stage_data[DIGITS]),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule

### design/sdas_checker.sv
// Port checker for the signed decimal unit and its bind to the top level.
`timescale 1ns / 1ps
module sdas_checker import sdas_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A result transaction that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // A zero magnitude never carries a minus sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_negative |-> out_data_o.result_digits != '0)
    else $error("negative sign on a zero result");

  // Only a compare sets greater_or_equal, and a compare leaves the other fields zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.greater_or_equal |->
      out_data_o.result_digits == '0 && !out_data_o.result_negative &&
      !out_data_o.overflow)
    else $error("compare result mixed with arithmetic result");

endmodule

bind signed_decimal_add_sub_compare sdas_checker u_sdas_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
